[hdl/bmau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmau_pkg
// Shared types and codes for the multiprecision arithmetic unit.
// ----------------------------------------------------------------------------
package bmau_pkg;

  localparam int WORD_W    = 32;
  localparam int WORDS_DEF = 32;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_LOAD_N = 2'd2;
  localparam logic [1:0] MODE_EXEC   = 2'd3;

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_CMP    = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_SQR    = 4'd4;
  localparam logic [3:0] OP_DIV    = 4'd5;
  localparam logic [3:0] OP_MOD    = 4'd6;
  localparam logic [3:0] OP_GCD    = 4'd7;
  localparam logic [3:0] OP_LCM    = 4'd8;
  localparam logic [3:0] OP_MODADD = 4'd9;
  localparam logic [3:0] OP_MODSUB = 4'd10;
  localparam logic [3:0] OP_MODMUL = 4'd11;
  localparam logic [3:0] OP_MODSQR = 4'd12;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NEG  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_RSUB,
    K_MAC,
    K_DIV
  } alu_kind_t;

  typedef struct packed {
    alu_kind_t kind;
    logic      first;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEQ,
    S_PASS,
    S_MUL_PASS,
    S_MUL_NEXT,
    S_DIV_PASS,
    S_DIV_FIN,
    S_G_START,
    S_G_TWO,
    S_G_U,
    S_G_V,
    S_G_CHK,
    S_G_FIX,
    S_EMIT
  } state_t;

endpackage

[hdl/bmau_word_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmau_word_alu
// Shared one-word unit: add, subtract, multiply-accumulate and divide step,
// each with a carry or borrow chained from the previous word.
// ----------------------------------------------------------------------------
module bmau_word_alu (
  input  bmau_pkg::alu_ctl_t ctl,
  input  logic [31:0]        x,
  input  logic [31:0]        y,
  input  logic [31:0]        z,
  input  logic [31:0]        m,
  input  logic [31:0]        cin,
  input  logic               bin,
  output logic [31:0]        res,
  output logic [31:0]        cout,
  output logic [31:0]        xs
);
  import bmau_pkg::*;

  logic [31:0] c;
  logic [32:0] t33;
  logic [63:0] prod;
  logic [63:0] t64;

  always_comb begin
    c    = ctl.first ? 32'd0 : cin;
    xs   = {x[30:0], bin};
    prod = 64'(m) * 64'(y);
    t33  = 33'd0;
    t64  = 64'd0;
    case (ctl.kind)
      K_ADD: begin
        t33  = {1'b0, x} + {1'b0, y} + {32'd0, c[0]};
        res  = t33[31:0];
        cout = {31'd0, t33[32]};
      end
      K_SUB: begin
        t33  = {1'b0, x} - {1'b0, y} - {32'd0, c[0]};
        res  = t33[31:0];
        cout = {31'd0, t33[32]};
      end
      K_RSUB: begin
        t33  = {1'b0, y} - {1'b0, x} - {32'd0, c[0]};
        res  = t33[31:0];
        cout = {31'd0, t33[32]};
      end
      K_DIV: begin
        t33  = {1'b0, xs} - {1'b0, y} - {32'd0, c[0]};
        res  = t33[31:0];
        cout = {31'd0, t33[32]};
      end
      K_MAC: begin
        t64  = prod + {32'd0, z} + {32'd0, c};
        res  = t64[31:0];
        cout = t64[63:32];
      end
      default: begin
        res  = 32'd0;
        cout = 32'd0;
      end
    endcase
  end

endmodule

[hdl/bignum_modular_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bignum_modular_arithmetic_unit
// Unsigned multiprecision arithmetic on WORDS-word operands, word-serial.
// ----------------------------------------------------------------------------
// Loads write one operand word. An execute runs 2*WORDS-word passes through
// one shared word unit: add/sub/cmp one pass, mul WORDS passes, divide one
// pass per dividend bit (32*WORDS or 64*WORDS), gcd up to about 128*WORDS
// passes; results then stream one word per accepted cycle.
// Synchronous reset clears the sequencer and the operands A, B and N.
// ----------------------------------------------------------------------------
module bignum_modular_arithmetic_unit #(
  parameter int WORDS = bmau_pkg::WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [4:0]  word_sel,
  input  logic [31:0] word_value,
  input  logic [3:0]  operation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_word,
  output logic [5:0]  result_index,
  output logic        last,
  output logic [1:0]  status,
  output logic signed [1:0] compare
);
  import bmau_pkg::*;

  localparam int DW  = 2 * WORDS;
  localparam int VW  = WORDS * WORD_W;
  localparam int DVW = DW * WORD_W;
  localparam int WCW = $clog2(DW);
  localparam int BCW = $clog2(DVW + 1);
  localparam int OCW = $clog2(DW + 1);

  state_t state, state_next, pass_ret, pass_ret_next;
  logic [3:0] op, op_next;
  logic [2:0] phase, phase_next;
  logic [VW-1:0] a_reg, a_next, b_reg, b_next, n_reg, n_next;
  logic [DVW-1:0] x, x_next, y, y_next, z, z_next, q, q_next, s, s_next;
  logic [WCW-1:0] wcnt, wcnt_next;
  logic [BCW-1:0] bcnt, bcnt_next;
  logic [OCW-1:0] ocnt, ocnt_next, olen, olen_next;
  logic [31:0] carry, carry_next, yprev, yprev_next;
  logic nz, nz_next, prevb, prevb_next;
  alu_kind_t pass_kind, pass_kind_next;
  logic [1:0] status_r, status_next;
  logic signed [1:0] cmp_r, cmp_next;

  alu_ctl_t alu_ctl;
  logic [31:0] alu_res, alu_cout, alu_xs;

  // sequencer requests
  logic dv_go, dv_single, mul_go, mul_sq, em_go, er_go, pass_go;
  logic [DVW-1:0] dv_src, dv_div, em_src;
  logic [OCW-1:0] em_len;
  logic [1:0] er_code;
  alu_kind_t pass_k;
  state_t pass_r;
  logic last_pass;

  bmau_word_alu u_alu (
    .ctl  (alu_ctl),
    .x    (x[31:0]),
    .y    (y[31:0]),
    .z    (z[31:0]),
    .m    (x[31:0]),
    .cin  (carry),
    .bin  ((wcnt == '0) ? q[DVW-1] : prevb),
    .res  (alu_res),
    .cout (alu_cout),
    .xs   (alu_xs)
  );

  always_comb begin
    state_next     = state;
    pass_ret_next  = pass_ret;
    op_next        = op;
    phase_next     = phase;
    a_next         = a_reg;
    b_next         = b_reg;
    n_next         = n_reg;
    x_next         = x;
    y_next         = y;
    z_next         = z;
    q_next         = q;
    s_next         = s;
    wcnt_next      = wcnt;
    bcnt_next      = bcnt;
    ocnt_next      = ocnt;
    olen_next      = olen;
    carry_next     = carry;
    yprev_next     = yprev;
    nz_next        = nz;
    prevb_next     = prevb;
    pass_kind_next = pass_kind;
    status_next    = status_r;
    cmp_next       = cmp_r;
    dv_go = 1'b0; dv_single = 1'b1; dv_src = '0; dv_div = '0;
    mul_go = 1'b0; mul_sq = 1'b0;
    em_go = 1'b0; em_src = '0; em_len = '0;
    er_go = 1'b0; er_code = ST_OK;
    pass_go = 1'b0; pass_k = K_ADD; pass_r = S_SEQ;
    last_pass = (wcnt == WCW'(DW - 1));

    alu_ctl.first = (wcnt == '0);
    case (state)
      S_MUL_PASS: alu_ctl.kind = K_MAC;
      S_DIV_PASS: alu_ctl.kind = K_DIV;
      default:    alu_ctl.kind = pass_kind;
    endcase

    in_ready  = (state == S_IDLE);
    out_valid = (state == S_EMIT);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (mode != MODE_EXEC) begin
            if (32'(word_sel) < WORDS) begin
              case (mode)
                MODE_LOAD_A: a_next[word_sel*WORD_W +: WORD_W] = word_value;
                MODE_LOAD_B: b_next[word_sel*WORD_W +: WORD_W] = word_value;
                default:     n_next[word_sel*WORD_W +: WORD_W] = word_value;
              endcase
            end
          end else if (operation <= OP_MODSQR) begin
            op_next    = operation;
            phase_next = 3'd0;
            state_next = S_SEQ;
          end
        end
      end

      S_SEQ: begin
        phase_next = phase + 3'd1;
        case (op)
          OP_ADD, OP_SUB, OP_CMP: begin
            if (phase == 3'd0) begin
              x_next  = {{VW{1'b0}}, a_reg};
              y_next  = {{VW{1'b0}}, b_reg};
              pass_go = 1'b1;
              pass_k  = (op == OP_ADD) ? K_ADD : K_SUB;
            end else if (op == OP_CMP) begin
              em_go    = 1'b1;
              em_len   = OCW'(1);
              cmp_next = carry[0] ? 2'sb11 : (nz ? 2'sb01 : 2'sb00);
            end else if (op == OP_SUB && carry[0]) begin
              er_go = 1'b1; er_code = ST_NEG;
            end else begin
              em_go = 1'b1; em_src = {{VW{1'b0}}, z[VW-1:0]}; em_len = OCW'(WORDS);
            end
          end
          OP_MUL, OP_SQR: begin
            if (phase == 3'd0) begin
              mul_go = 1'b1; mul_sq = (op == OP_SQR);
            end else begin
              em_go = 1'b1; em_src = z; em_len = OCW'(DW);
            end
          end
          OP_DIV, OP_MOD: begin
            if (phase == 3'd0) begin
              if (~|b_reg) begin
                er_go = 1'b1; er_code = ST_DIV0;
              end else begin
                dv_go = 1'b1; dv_src = {{VW{1'b0}}, a_reg}; dv_div = {{VW{1'b0}}, b_reg};
              end
            end else begin
              em_go  = 1'b1;
              em_src = (op == OP_DIV) ? {{VW{1'b0}}, q[VW-1:0]} : x;
              em_len = OCW'(WORDS);
            end
          end
          OP_GCD, OP_LCM: begin
            case (phase)
              3'd0: begin
                x_next     = {{VW{1'b0}}, a_reg};
                y_next     = {{VW{1'b0}}, b_reg};
                state_next = S_G_START;
              end
              3'd1: begin
                if (op == OP_GCD) begin
                  em_go = 1'b1; em_src = x; em_len = OCW'(WORDS);
                end else if (~|x) begin
                  er_go = 1'b1; er_code = ST_DIV0;
                end else begin
                  // park the gcd in q while the product is formed
                  q_next = x;
                  mul_go = 1'b1;
                end
              end
              3'd2: begin
                dv_go = 1'b1; dv_single = 1'b0; dv_src = z; dv_div = q;
              end
              default: begin
                em_go = 1'b1; em_src = q; em_len = OCW'(DW);
              end
            endcase
          end
          OP_MODADD: begin
            case (phase)
              3'd0: begin
                if (~|n_reg) begin
                  er_go = 1'b1; er_code = ST_DIV0;
                end else begin
                  dv_go = 1'b1; dv_src = {{VW{1'b0}}, a_reg}; dv_div = {{VW{1'b0}}, n_reg};
                end
              end
              3'd1: begin
                s_next = x;
                dv_go  = 1'b1; dv_src = {{VW{1'b0}}, b_reg}; dv_div = {{VW{1'b0}}, n_reg};
              end
              3'd2: begin
                y_next  = s;
                pass_go = 1'b1;
                pass_k  = K_ADD;
              end
              3'd3: begin
                dv_go  = 1'b1;
                dv_src = {{VW{1'b0}}, z[VW-1:0]};
                dv_div = {{VW{1'b0}}, n_reg};
              end
              default: begin
                em_go = 1'b1; em_src = x; em_len = OCW'(WORDS);
              end
            endcase
          end
          OP_MODSUB: begin
            case (phase)
              3'd0: begin
                x_next  = {{VW{1'b0}}, a_reg};
                y_next  = {{VW{1'b0}}, b_reg};
                pass_go = 1'b1;
                pass_k  = K_SUB;
              end
              3'd1: begin
                if (carry[0]) begin
                  er_go = 1'b1; er_code = ST_NEG;
                end else if (~|n_reg) begin
                  er_go = 1'b1; er_code = ST_DIV0;
                end else begin
                  dv_go  = 1'b1;
                  dv_src = {{VW{1'b0}}, z[VW-1:0]};
                  dv_div = {{VW{1'b0}}, n_reg};
                end
              end
              default: begin
                em_go = 1'b1; em_src = x; em_len = OCW'(WORDS);
              end
            endcase
          end
          OP_MODMUL, OP_MODSQR: begin
            case (phase)
              3'd0: begin
                if (~|n_reg) begin
                  er_go = 1'b1; er_code = ST_DIV0;
                end else begin
                  mul_go = 1'b1; mul_sq = (op == OP_MODSQR);
                end
              end
              3'd1: begin
                dv_go = 1'b1; dv_single = 1'b0; dv_src = z;
                dv_div = {{VW{1'b0}}, n_reg};
              end
              default: begin
                em_go = 1'b1; em_src = x; em_len = OCW'(DW);
              end
            endcase
          end
          default: state_next = S_IDLE;
        endcase
      end

      S_PASS: begin
        x_next     = {x[31:0], x[DVW-1:32]};
        y_next     = {y[31:0], y[DVW-1:32]};
        z_next     = {alu_res, z[DVW-1:32]};
        carry_next = alu_cout;
        nz_next    = (alu_ctl.first ? 1'b0 : nz) | (alu_res != 32'd0);
        wcnt_next  = wcnt + 1'b1;
        if (last_pass) begin
          wcnt_next  = '0;
          state_next = pass_ret;
        end
      end

      S_MUL_PASS: begin
        // shift y up one word as it rotates
        yprev_next = y[31:0];
        y_next     = {(alu_ctl.first ? 32'd0 : yprev), y[DVW-1:32]};
        z_next     = {alu_res, z[DVW-1:32]};
        carry_next = alu_cout;
        wcnt_next  = wcnt + 1'b1;
        if (last_pass) begin
          wcnt_next  = '0;
          state_next = S_MUL_NEXT;
        end
      end

      S_MUL_NEXT: begin
        x_next    = {32'd0, x[DVW-1:32]};
        bcnt_next = bcnt - 1'b1;
        state_next = (bcnt == BCW'(1)) ? S_SEQ : S_MUL_PASS;
      end

      S_DIV_PASS: begin
        prevb_next = x[31];
        x_next     = {alu_xs, x[DVW-1:32]};
        y_next     = {y[31:0], y[DVW-1:32]};
        z_next     = {alu_res, z[DVW-1:32]};
        carry_next = alu_cout;
        wcnt_next  = wcnt + 1'b1;
        if (last_pass) begin
          wcnt_next  = '0;
          state_next = S_DIV_FIN;
        end
      end

      S_DIV_FIN: begin
        if (!carry[0]) x_next = z;
        q_next     = {q[DVW-2:0], ~carry[0]};
        bcnt_next  = bcnt - 1'b1;
        state_next = (bcnt == BCW'(1)) ? S_SEQ : S_DIV_PASS;
      end

      S_G_START: begin
        bcnt_next = '0;
        if (~|x) begin
          x_next     = y;
          state_next = S_SEQ;
        end else if (~|y) begin
          state_next = S_SEQ;
        end else begin
          state_next = S_G_TWO;
        end
      end

      S_G_TWO: begin
        if (!x[0] && !y[0]) begin
          x_next    = {1'b0, x[DVW-1:1]};
          y_next    = {1'b0, y[DVW-1:1]};
          bcnt_next = bcnt + 1'b1;
        end else begin
          state_next = S_G_U;
        end
      end

      S_G_U: begin
        if (!x[0]) x_next = {1'b0, x[DVW-1:1]};
        else state_next = S_G_V;
      end

      S_G_V: begin
        if (!y[0]) begin
          y_next = {1'b0, y[DVW-1:1]};
        end else begin
          pass_go = 1'b1;
          pass_k  = K_RSUB;
          pass_r  = S_G_CHK;
        end
      end

      S_G_CHK: begin
        if (carry[0]) begin
          // v < u: swap and subtract again
          x_next     = y;
          y_next     = x;
          state_next = S_G_V;
        end else begin
          y_next     = z;
          state_next = nz ? S_G_V : S_G_FIX;
        end
      end

      S_G_FIX: begin
        if (bcnt != '0) begin
          x_next    = {x[DVW-2:0], 1'b0};
          bcnt_next = bcnt - 1'b1;
        end else begin
          state_next = S_SEQ;
        end
      end

      S_EMIT: begin
        if (out_ready) begin
          q_next    = {32'd0, q[DVW-1:32]};
          ocnt_next = ocnt + 1'b1;
          if (ocnt == olen - 1'b1) state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    if (pass_go) begin
      pass_kind_next = pass_k;
      pass_ret_next  = pass_r;
      wcnt_next      = '0;
      state_next     = S_PASS;
    end
    if (mul_go) begin
      x_next     = {{VW{1'b0}}, a_reg};
      y_next     = {{VW{1'b0}}, (mul_sq ? a_reg : b_reg)};
      z_next     = '0;
      bcnt_next  = BCW'(WORDS);
      wcnt_next  = '0;
      state_next = S_MUL_PASS;
    end
    if (dv_go) begin
      if (dv_single) begin
        q_next    = {dv_src[VW-1:0], {VW{1'b0}}};
        bcnt_next = BCW'(VW);
      end else begin
        q_next    = dv_src;
        bcnt_next = BCW'(DVW);
      end
      y_next     = dv_div;
      x_next     = '0;
      wcnt_next  = '0;
      state_next = S_DIV_PASS;
    end
    if (em_go) begin
      q_next      = em_src;
      olen_next   = em_len;
      ocnt_next   = '0;
      status_next = ST_OK;
      if (op != OP_CMP) cmp_next = 2'sb00;
      state_next  = S_EMIT;
    end
    if (er_go) begin
      q_next      = '0;
      olen_next   = OCW'(1);
      ocnt_next   = '0;
      status_next = er_code;
      cmp_next    = 2'sb00;
      state_next  = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      a_reg <= '0;
      b_reg <= '0;
      n_reg <= '0;
    end else begin
      state <= state_next;
      a_reg <= a_next;
      b_reg <= b_next;
      n_reg <= n_next;
    end
  end

  always_ff @(posedge clk) begin
    pass_ret  <= pass_ret_next;
    op        <= op_next;
    phase     <= phase_next;
    x         <= x_next;
    y         <= y_next;
    z         <= z_next;
    q         <= q_next;
    s         <= s_next;
    wcnt      <= wcnt_next;
    bcnt      <= bcnt_next;
    ocnt      <= ocnt_next;
    olen      <= olen_next;
    carry     <= carry_next;
    yprev     <= yprev_next;
    nz        <= nz_next;
    prevb     <= prevb_next;
    pass_kind <= pass_kind_next;
    status_r  <= status_next;
    cmp_r     <= cmp_next;
  end

  assign result_word  = q[31:0];
  assign result_index = 6'(ocnt);
  assign last         = (ocnt == olen - 1'b1);
  assign status       = status_r;
  assign compare      = cmp_r;

endmodule
